>>> hdl/mpqm_pkg.sv
// Shared constants, codes and controller/datapath link types for the
// message pool queue manager. No dependencies.
package mpqm_pkg;

   localparam int POOL_SIZE   = 16;
   localparam int HANDLE_W    = 4;
   localparam int FCNT_W      = 5;
   localparam int NUM_DEST    = 8;
   localparam int DEST_W      = 3;
   localparam int QUEUE_DEPTH = 16;
   localparam int QIDX_W      = 4;
   localparam int QCNT_W      = 5;
   localparam int STORE_DEPTH = NUM_DEST * QUEUE_DEPTH;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
   localparam logic [OP_W-1:0] OP_SEND  = 3'd2;
   localparam logic [OP_W-1:0] OP_RECV  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_EMPTY = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_MSG     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd4;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic clear_init;
      logic clear_step;
      logic finish;
   } mpqm_cmd_type;

   typedef struct packed {
      logic out_free;
      logic op_clear;
      logic clear_last;
   } mpqm_stat_type;

endpackage

>>> hdl/mpqm_req_if.sv
// Request channel: valid/ready handshake with one operation beat.
// Depends on mpqm_pkg.
interface mpqm_req_if;
   import mpqm_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [HANDLE_W-1:0] handle;
   logic [DEST_W-1:0]   destination;

   modport source (output valid, output operation, output handle, output destination,
                   input ready);
   modport sink   (input valid, input operation, input handle, input destination,
                   output ready);
endinterface

>>> hdl/mpqm_rsp_if.sv
// Response channel: valid/ready handshake with one result beat.
// Depends on mpqm_pkg.
interface mpqm_rsp_if;
   import mpqm_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] result_handle;

   modport source (output valid, output status, output result_handle, input ready);
   modport sink   (input valid, input status, input result_handle, output ready);
endinterface

>>> hdl/mpqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/mpqm_ctrl.sv
// Controller state machine: request handshake and sequencing of the datapath.
// Depends on mpqm_pkg.
module mpqm_ctrl
   import mpqm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  mpqm_stat_type stat,
   output mpqm_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_CLEAR  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.op_clear) begin
               cmd.clear_init = 1'b1;
               state_in       = S_CLEAR;
            end else if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/mpqm_datapath.sv
// Datapath: free list, used marks, queue pointers, queue store and result register.
// Depends on mpqm_pkg and mpqm_ram.
module mpqm_datapath
   import mpqm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  mpqm_cmd_type        cmd,
   output mpqm_stat_type       stat,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic [DEST_W-1:0]   req_destination,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HANDLE_W-1:0] rsp_result_handle
);

   logic [OP_W-1:0]     op_ff, op_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [DEST_W-1:0]   dest_ff, dest_in;

   logic [HANDLE_W-1:0] free_list_ff [POOL_SIZE];
   logic [HANDLE_W-1:0] free_list_in [POOL_SIZE];
   logic [HANDLE_W-1:0] free_head_ff, free_head_in;
   logic [FCNT_W-1:0]   free_count_ff, free_count_in;
   logic [POOL_SIZE-1:0] used_ff, used_in;

   logic [QIDX_W-1:0] q_head_ff  [NUM_DEST];
   logic [QIDX_W-1:0] q_head_in  [NUM_DEST];
   logic [QCNT_W-1:0] q_count_ff [NUM_DEST];
   logic [QCNT_W-1:0] q_count_in [NUM_DEST];

   logic [HANDLE_W-1:0] walk_ff, walk_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [HANDLE_W-1:0] rh_ff, rh_in;

   logic                out_load;
   logic [HANDLE_W-1:0] free_tail;
   logic                free_room;
   logic [HANDLE_W-1:0] alloc_handle;

   logic                         wr_en;
   logic [DEST_W+QIDX_W-1:0]     wr_addr;
   logic [DEST_W+QIDX_W-1:0]     rd_addr;
   logic [HANDLE_W-1:0]          rd_data;

   mpqm_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (handle_ff),
      .rd_en   (cmd.load_req),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read the head of the addressed queue on the accept beat; data is ready in EXEC.
   assign rd_addr = {req_destination, q_head_ff[req_destination]};

   assign free_tail    = free_head_ff + free_count_ff[HANDLE_W-1:0];
   assign free_room    = (free_count_ff != FCNT_W'(POOL_SIZE));
   assign alloc_handle = free_list_ff[free_head_ff];

   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.op_clear   = (op_ff == OP_CLEAR);
   assign stat.clear_last = (walk_ff == HANDLE_W'(POOL_SIZE - 1));

   always_comb begin
      op_in         = op_ff;
      handle_in     = handle_ff;
      dest_in       = dest_ff;
      free_list_in  = free_list_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      used_in       = used_ff;
      q_head_in     = q_head_ff;
      q_count_in    = q_count_ff;
      walk_in       = walk_ff;
      wr_en         = 1'b0;
      wr_addr       = {dest_ff, q_head_ff[dest_ff] + q_count_ff[dest_ff][QIDX_W-1:0]};
      out_load      = 1'b0;
      status_in     = ST_OK;
      rh_in         = '0;

      if (cmd.load_req) begin
         op_in     = req_operation;
         handle_in = req_handle;
         dest_in   = req_destination;
      end

      if (cmd.exec) begin
         out_load = 1'b1;
         unique case (op_ff)
            OP_ALLOC: begin
               if (free_count_ff == '0) begin
                  status_in = ST_POOL_EMPTY;
               end else begin
                  rh_in                 = alloc_handle;
                  used_in[alloc_handle] = 1'b1;
                  free_head_in          = free_head_ff + 1'b1;
                  free_count_in         = free_count_ff - 1'b1;
               end
            end
            OP_FREE: begin
               if (!used_ff[handle_ff]) begin
                  status_in = ST_NOT_ALLOC;
               end else begin
                  used_in[handle_ff] = 1'b0;
                  if (free_room) begin
                     free_list_in[free_tail] = handle_ff;
                     free_count_in           = free_count_ff + 1'b1;
                  end
               end
            end
            OP_SEND: begin
               if (!used_ff[handle_ff]) begin
                  status_in = ST_NOT_ALLOC;
               end else if (q_count_ff[dest_ff] == QCNT_W'(QUEUE_DEPTH)) begin
                  status_in = ST_QUEUE_FULL;
               end else begin
                  wr_en               = 1'b1;
                  q_count_in[dest_ff] = q_count_ff[dest_ff] + 1'b1;
               end
            end
            OP_RECV: begin
               if (q_count_ff[dest_ff] == '0) begin
                  status_in = ST_NO_MSG;
               end else begin
                  rh_in               = rd_data;
                  q_head_in[dest_ff]  = q_head_ff[dest_ff] + 1'b1;
                  q_count_in[dest_ff] = q_count_ff[dest_ff] - 1'b1;
               end
            end
            default: begin
               // unknown codes: answer ok, change nothing
            end
         endcase
      end

      if (cmd.clear_init) begin
         for (int d = 0; d < NUM_DEST; d++) begin
            q_head_in[d]  = '0;
            q_count_in[d] = '0;
         end
         walk_in = '0;
      end

      // Walk handles in ascending order; return each used one to the free tail.
      if (cmd.clear_step) begin
         walk_in = walk_ff + 1'b1;
         if (used_ff[walk_ff]) begin
            used_in[walk_ff] = 1'b0;
            if (free_room) begin
               free_list_in[free_tail] = walk_ff;
               free_count_in           = free_count_ff + 1'b1;
            end
         end
      end

      if (cmd.finish) begin
         out_load = 1'b1;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_SIZE; i++) begin
            free_list_ff[i] <= HANDLE_W'(i);
         end
         free_head_ff  <= '0;
         free_count_ff <= FCNT_W'(POOL_SIZE);
         used_ff       <= '0;
         for (int d = 0; d < NUM_DEST; d++) begin
            q_head_ff[d]  <= '0;
            q_count_ff[d] <= '0;
         end
         walk_ff      <= '0;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_list_ff  <= free_list_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         used_ff       <= used_in;
         q_head_ff     <= q_head_in;
         q_count_ff    <= q_count_in;
         walk_ff       <= walk_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      dest_ff   <= dest_in;
      if (out_load) begin
         status_ff <= status_in;
         rh_ff     <= rh_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_handle = rh_ff;

endmodule

>>> hdl/message_pool_queue_manager.sv
// Top level of the message pool queue manager: controller plus datapath.
// Depends on mpqm_pkg, mpqm_req_if, mpqm_rsp_if, mpqm_ctrl and mpqm_datapath.
//
// Manages a pool of 16 message buffer handles with a FIFO free list (reset loads
// handles 0..15 in order), a used mark per handle, and eight 16-deep handle
// queues, one per destination. Each request beat carries an operation
// (allocate, free, send, receive, clear all) and yields exactly one response
// beat with a status and, for a good allocate or receive, the handle. Requests
// are served one at a time: allocate, free, send and receive pass from the
// accept beat, which also reads the queue store, to a read-modify-write of the
// pool and queue state that loads the response; clear all first resets the
// queue pointers, then walks all 16 handles, one handle a cycle, returning used
// handles to the free list in ascending order. The response sits in an output
// register, so the next request is taken while an earlier response still waits
// for rsp_if.ready; the block stalls only when a finished result has nowhere to
// go. Queue contents live in a 128-entry RAM with registered read.
module message_pool_queue_manager
   import mpqm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mpqm_req_if.sink   req_if,
   mpqm_rsp_if.source rsp_if
);

   mpqm_cmd_type  cmd;
   mpqm_stat_type stat;

   // Sequence each request: accept, execute or walk, then post the response.
   mpqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold all pool and queue state; drive the response register.
   mpqm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_if.operation),
      .req_handle        (req_if.handle),
      .req_destination   (req_if.destination),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_status        (rsp_if.status),
      .rsp_result_handle (rsp_if.result_handle)
   );

endmodule
